[src/touch_gesture_classifier_macros.svh]
// Assertion macros shared by the touch gesture classifier modules.
// Each macro expects signals named clock and reset in the using module.
`ifndef TOUCH_GESTURE_CLASSIFIER_MACROS_SVH
`define TOUCH_GESTURE_CLASSIFIER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TGC_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("touch gesture classifier assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TGC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("touch gesture classifier assertion failed");

`endif

[src/tgc_pkg.sv]
// Package for the touch gesture classifier: register indexes, reset values
// and the structs passed between the control, core and top level modules.
`timescale 1ns / 1ps

package tgc_pkg;

   localparam int TGC_TIME_WIDTH = 32;
   localparam int CSR_DATA_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int NOW_WIDTH = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DOUBLE_TAP_WINDOW = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG_PRESS_TIME = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CONFIG_PRESS_TIME = 2'd2;

   localparam logic [CSR_DATA_WIDTH-1:0] RESET_DOUBLE_TAP_WINDOW = 16'd300;
   localparam logic [CSR_DATA_WIDTH-1:0] RESET_LONG_PRESS_TIME = 16'd800;
   localparam logic [CSR_DATA_WIDTH-1:0] RESET_CONFIG_PRESS_TIME = 16'd5000;

   typedef struct packed {
      logic [CSR_DATA_WIDTH-1:0] double_tap_window;
      logic [CSR_DATA_WIDTH-1:0] long_press_time;
      logic [CSR_DATA_WIDTH-1:0] config_press_time;
   } tgc_cfg_type;

   typedef struct packed {
      logic single_tap;
      logic double_tap;
      logic long_press;
      logic config_press;
   } tgc_pulse_type;

endpackage

[src/tgc_csr.sv]
// Configuration registers of the touch gesture classifier.
// Depends on tgc_pkg for the register indexes and reset values.
`timescale 1ns / 1ps

module tgc_csr
   import tgc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   output tgc_cfg_type                cfg
);

   tgc_cfg_type cfg_ff;
   tgc_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_DOUBLE_TAP_WINDOW: cfg_in.double_tap_window = csr_write_data;
            CSR_LONG_PRESS_TIME:   cfg_in.long_press_time = csr_write_data;
            CSR_CONFIG_PRESS_TIME: cfg_in.config_press_time = csr_write_data;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.double_tap_window <= RESET_DOUBLE_TAP_WINDOW;
         cfg_ff.long_press_time <= RESET_LONG_PRESS_TIME;
         cfg_ff.config_press_time <= RESET_CONFIG_PRESS_TIME;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[src/tgc_core.sv]
// Gesture state and classification logic of the touch gesture classifier.
// Depends on tgc_pkg and the shared assertion macros.
`timescale 1ns / 1ps
`include "touch_gesture_classifier_macros.svh"

module tgc_core
   import tgc_pkg::*;
#(
   parameter int TIME_WIDTH = TGC_TIME_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  touched,
   input  logic [TIME_WIDTH-1:0] now,
   input  tgc_cfg_type           cfg,
   output tgc_pulse_type         pulse
);

   logic is_pressed_ff, is_pressed_in;
   logic single_pending_ff, single_pending_in;
   logic long_done_ff, long_done_in;
   logic config_done_ff, config_done_in;
   logic second_press_ff, second_press_in;
   logic [TIME_WIDTH-1:0] press_start_ff, press_start_in;
   logic [TIME_WIDTH-1:0] release_stamp_ff, release_stamp_in;

   logic [TIME_WIDTH-1:0] since_release;
   logic [TIME_WIDTH-1:0] held_for;
   logic                  tap_expired;
   logic                  pending_live;

   // Differences wrap modulo the timestamp width.
   assign since_release = now - release_stamp_ff;
   assign held_for = now - press_start_ff;
   assign tap_expired = single_pending_ff &&
                        (since_release >= TIME_WIDTH'(cfg.double_tap_window));
   assign pending_live = single_pending_ff && !tap_expired;

   always_comb begin
      is_pressed_in = is_pressed_ff;
      single_pending_in = pending_live;
      long_done_in = long_done_ff;
      config_done_in = config_done_ff;
      second_press_in = second_press_ff;
      press_start_in = press_start_ff;
      release_stamp_in = release_stamp_ff;
      pulse = '0;
      pulse.single_tap = tap_expired;

      if (touched && !is_pressed_ff) begin
         // A pending tap that survived expiry is still inside the window.
         is_pressed_in = 1'b1;
         press_start_in = now;
         long_done_in = 1'b0;
         config_done_in = 1'b0;
         second_press_in = pending_live;
         single_pending_in = 1'b0;
         pulse.double_tap = pending_live;
      end else if (touched && !long_done_ff &&
                   (held_for >= TIME_WIDTH'(cfg.long_press_time))) begin
         pulse.long_press = 1'b1;
         long_done_in = 1'b1;
         single_pending_in = 1'b0;
      end else if (touched && !config_done_ff &&
                   (held_for >= TIME_WIDTH'(cfg.config_press_time))) begin
         pulse.config_press = 1'b1;
         config_done_in = 1'b1;
         single_pending_in = 1'b0;
      end else if (!touched && is_pressed_ff) begin
         is_pressed_in = 1'b0;
         if (!long_done_ff && !second_press_ff) begin
            single_pending_in = 1'b1;
            release_stamp_in = now;
         end
         second_press_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         is_pressed_ff <= 1'b0;
         single_pending_ff <= 1'b0;
         long_done_ff <= 1'b0;
         config_done_ff <= 1'b0;
         second_press_ff <= 1'b0;
      end else if (step) begin
         is_pressed_ff <= is_pressed_in;
         single_pending_ff <= single_pending_in;
         long_done_ff <= long_done_in;
         config_done_ff <= config_done_in;
         second_press_ff <= second_press_in;
      end
   end

   // The stamps are only read while the matching flag is set.
   always_ff @(posedge clock) begin
      if (step) begin
         press_start_ff <= press_start_in;
         release_stamp_ff <= release_stamp_in;
      end
   end

   `TGC_ASSERT_IMPL(a_one_pulse, step, $onehot0(pulse))
   `TGC_ASSERT_IMPL(a_pending_released, single_pending_ff, !is_pressed_ff)
   `TGC_ASSERT_IMPL(a_second_while_held, second_press_ff, is_pressed_ff)
   `TGC_ASSERT_NEXT(a_long_sets_done, step && pulse.long_press, long_done_ff && is_pressed_ff)

endmodule

[src/touch_gesture_classifier.sv]
// Touch gesture classifier: one touch sample in, one gesture result out.
// Channels carry valid and stall; a transfer happens when valid is high and
// stall is low. The request carries the touch level and a millisecond
// timestamp, the response carries four pulse flags of which at most one is set.
// Every accepted sample produces exactly one response, in order.
// A sample lands in the input register; when the result register is free, the
// core step writes the gesture state and the result register from it.
// Throughput is one sample per cycle while the receiver does not stall; the gesture
// state is read and updated by a single combinational pass from the input register.
// When the receiver stalls, the result register holds; an empty input register
// still takes one sample, and then req_stall rises until the result moves.
// Synchronous reset empties both registers, clears the gesture state and
// restores the configuration defaults (300, 800 and 5000 ms).
// Configuration writes through the csr_ port take effect on the next edge.
// Depends on tgc_pkg, tgc_csr and tgc_core.
`timescale 1ns / 1ps

module touch_gesture_classifier
   import tgc_pkg::*;
#(
   parameter int TIME_WIDTH = TGC_TIME_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_touched,
   input  logic [NOW_WIDTH-1:0]       req_now_ms,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_single_tap,
   output logic                       rsp_double_tap,
   output logic                       rsp_long_press,
   output logic                       rsp_config_press,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   logic                 in_valid_ff, in_valid_in;
   logic                 in_touched_ff;
   logic [NOW_WIDTH-1:0] in_now_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   tgc_pulse_type        rsp_pulse_ff;

   logic          out_free;
   logic          step;
   logic          req_take;
   tgc_cfg_type   cfg;
   tgc_pulse_type pulse;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign step = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take = req_valid && !req_stall;

   assign in_valid_in = req_take || (in_valid_ff && !step);
   assign rsp_valid_in = step || (rsp_valid_ff && rsp_stall);

   tgc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   tgc_core #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .touched (in_touched_ff),
      .now     (TIME_WIDTH'(in_now_ff)),
      .cfg     (cfg),
      .pulse   (pulse)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_touched_ff <= req_touched;
         in_now_ff <= req_now_ms;
      end
      if (step) begin
         rsp_pulse_ff <= pulse;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_single_tap = rsp_pulse_ff.single_tap;
   assign rsp_double_tap = rsp_pulse_ff.double_tap;
   assign rsp_long_press = rsp_pulse_ff.long_press;
   assign rsp_config_press = rsp_pulse_ff.config_press;

endmodule
